### sv/lfa_pkg.sv
// shared constants and codes for the lowest free id allocator
package lfa_pkg;

  // default sizes
  localparam int NUM_IDS_DEF   = 64;
  localparam int MAX_DELAY_DEF = 64;

  // widest slice of the free map examined per search cycle
  localparam int SCAN_W_MAX = 32;

  // configuration register width floor and reset values
  localparam int CFG_REG_W = 7;
  localparam int DELAY_RST = 1;
  localparam int COUNT_RST = 64;

  // item kinds (any other code is an idle step)
  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;

  // configuration register indexes
  localparam logic CFG_DELAY = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

endpackage

### sv/lfa_cell.sv
// one slot of the release quarantine ring
module lfa_cell #(
  parameter int IDW = 7
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic           hit,
  input  logic           drop,
  input  logic [IDW-1:0] ins_id,
  input  logic           nb_valid,
  input  logic [IDW-1:0] nb_id,
  output logic           out_valid,
  output logic [IDW-1:0] out_id,
  output logic           due_valid,
  output logic [IDW-1:0] due_id
);

  logic           valid;
  logic [IDW-1:0] id;

  // contents after this step's return and insert, handed to the neighbour
  always_comb begin
    if (hit) begin
      out_valid = 1'b1;
      out_id    = ins_id;
    end else if (drop) begin
      out_valid = 1'b0;
      out_id    = '0;
    end else begin
      out_valid = valid;
      out_id    = id;
    end
  end

  assign due_valid = valid;
  assign due_id    = id;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (step) begin
      valid <= nb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      id <= nb_id;
    end
  end

endmodule

### sv/lfa_scan.sv
// lowest set bit of one free map slice below the id limit
module lfa_scan #(
  parameter int SW = 32,
  parameter int AW = 7
) (
  input  logic [SW-1:0] bits,
  input  logic [AW-1:0] base,
  input  logic [AW-1:0] limit,
  output logic          found,
  output logic [AW-1:0] pos
);

  always_comb begin
    found = 1'b0;
    pos   = '0;
    // walk downwards so the lowest hit wins
    for (int j = SW - 1; j >= 0; j--) begin
      if (bits[j] && ((base + AW'(j)) < limit)) begin
        found = 1'b1;
        pos   = base + AW'(j);
      end
    end
  end

endmodule

### sv/lowest_free_id_allocator_delayed_release.sv
// top level: lowest free id allocator with a release quarantine ring
//
//  channel   signals                               direction  accepted when
//  --------  ------------------------------------  ---------  ----------------------
//  item in   start, busy, kind, release_id         in / out   start && !busy
//  result    done, granted_id, none_free           out        done (single cycle)
//  config    cfg_valid, cfg_ready, cfg_index,      in / out   cfg_valid && cfg_ready
//            cfg_data
//
// a release or idle item does not raise busy; the next item may follow at once
// an allocate holds busy while it searches, one free map slice
// of up to 32 ids examined per cycle, ending early at the first slice with a free
// id; done pulses on the cycle after the last one, with busy already low
// reset is synchronous: all ids free, ring empty, delay 1, count 64
// results cannot be stalled; each is shown for exactly one cycle
module lowest_free_id_allocator_delayed_release #(
  parameter int  NUM_IDS   = lfa_pkg::NUM_IDS_DEF,
  parameter int  MAX_DELAY = lfa_pkg::MAX_DELAY_DEF,
  localparam int IDW  = $clog2(NUM_IDS + 1),
  localparam int DW   = $clog2(MAX_DELAY + 1),
  localparam int CW0  = (DW > IDW) ? DW : IDW,
  localparam int CW   = (CW0 > lfa_pkg::CFG_REG_W) ? CW0 : lfa_pkg::CFG_REG_W
) (
  input  logic           clk,
  input  logic           rst,
  // item in
  input  logic           start,
  output logic           busy,
  input  logic [1:0]     kind,
  input  logic [IDW-1:0] release_id,
  // result
  output logic           done,
  output logic [IDW-1:0] granted_id,
  output logic           none_free,
  // configuration
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [CW-1:0]  cfg_data
);

  import lfa_pkg::*;

  // free map geometry
  localparam int SW     = (NUM_IDS < SCAN_W_MAX) ? NUM_IDS : SCAN_W_MAX;
  localparam int NCHUNK = (NUM_IDS + SW - 1) / SW;
  localparam int FW     = NCHUNK * SW;
  localparam int AW     = $clog2(FW + 1);
  localparam int FIW    = $clog2(FW);
  localparam int CIW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  // ring position width
  localparam int PW     = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;

  // control states
  localparam logic S_IDLE   = 1'b0;
  localparam logic S_SEARCH = 1'b1;

  logic           state;
  logic [CIW-1:0] chunk;

  logic [CW-1:0]  delay_reg;
  logic [CW-1:0]  count_reg;
  logic [DW-1:0]  eff_delay;
  logic [IDW-1:0] eff_count;

  // bit i marks id i+1 free; bits NUM_IDS and above are padding, always masked
  logic [FW-1:0]  free_map;

  logic           acc;
  logic           ret_valid;
  logic [IDW-1:0] ret_id;
  logic [AW-1:0]  ret_idx;
  logic [AW-1:0]  rid_idx;
  logic           rid_in_range;
  logic           rid_free;
  logic           rel_ok;
  logic [PW-1:0]  ins_off;
  logic [MAX_DELAY-1:0] hit;

  logic [MAX_DELAY-1:0] cell_v;
  logic [IDW-1:0]       cell_id [MAX_DELAY];

  logic [AW-1:0]  base;
  logic [AW:0]    next_base;
  logic [AW-1:0]  limit;
  logic           scan_found;
  logic [AW-1:0]  scan_pos;
  logic           last_chunk;

  assign cfg_ready = 1'b1;
  assign busy      = (state == S_SEARCH);
  assign acc       = start && !busy;

  // configuration registers, held raw and clamped on use
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_reg <= CW'(DELAY_RST);
      count_reg <= CW'(COUNT_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DELAY: delay_reg <= cfg_data;
        CFG_COUNT: count_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (delay_reg == '0) begin
      eff_delay = DW'(1);
    end else if (delay_reg > CW'(MAX_DELAY)) begin
      eff_delay = DW'(MAX_DELAY);
    end else begin
      eff_delay = delay_reg[DW-1:0];
    end
    if (count_reg == '0) begin
      eff_count = IDW'(1);
    end else if (count_reg > CW'(NUM_IDS)) begin
      eff_count = IDW'(NUM_IDS);
    end else begin
      eff_count = count_reg[IDW-1:0];
    end
  end

  // a delay of the full ring length lands back on the slot being emptied
  assign ins_off = (eff_delay == DW'(MAX_DELAY)) ? '0 : eff_delay[PW-1:0];

  // release check sees the free map after this step's return
  assign ret_idx      = AW'(ret_id) - AW'(1);
  assign rid_idx      = AW'(release_id) - AW'(1);
  assign rid_in_range = (release_id != '0) && (release_id <= eff_count);
  assign rid_free     = (rid_in_range && free_map[rid_idx[FIW-1:0]]) ||
                        (ret_valid && (ret_id == release_id));
  assign rel_ok       = acc && (kind == KIND_RELEASE) && rid_in_range && !rid_free;

  // quarantine ring: cell k holds what falls due k steps from now,
  // every step the row rotates one place towards cell 0
  for (genvar k = 0; k < MAX_DELAY; k++) begin : g_ring
    assign hit[k] = rel_ok && (ins_off == PW'(k));
    if (k == 0) begin : g_head
      lfa_cell #(
        .IDW(IDW)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .step      (acc),
        .hit       (hit[k]),
        .drop      (1'b1),
        .ins_id    (release_id),
        .nb_valid  (cell_v[(k + 1) % MAX_DELAY]),
        .nb_id     (cell_id[(k + 1) % MAX_DELAY]),
        .out_valid (cell_v[k]),
        .out_id    (cell_id[k]),
        .due_valid (ret_valid),
        .due_id    (ret_id)
      );
    end else begin : g_body
      lfa_cell #(
        .IDW(IDW)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .step      (acc),
        .hit       (hit[k]),
        .drop      (1'b0),
        .ins_id    (release_id),
        .nb_valid  (cell_v[(k + 1) % MAX_DELAY]),
        .nb_id     (cell_id[(k + 1) % MAX_DELAY]),
        .out_valid (cell_v[k]),
        .out_id    (cell_id[k]),
        .due_valid (),
        .due_id    ()
      );
    end
  end

  // slice search over the free map
  assign base       = AW'(chunk) * AW'(SW);
  assign next_base  = {1'b0, base} + (AW + 1)'(SW);
  assign limit      = AW'(eff_count);
  assign last_chunk = (chunk == CIW'(NCHUNK - 1)) || (next_base >= {1'b0, limit});

  lfa_scan #(
    .SW(SW),
    .AW(AW)
  ) u_scan (
    .bits  (free_map[base[FIW-1:0] +: SW]),
    .base  (base),
    .limit (limit),
    .found (scan_found),
    .pos   (scan_pos)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      chunk <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (acc && (kind == KIND_ALLOC)) begin
            state <= S_SEARCH;
            chunk <= '0;
          end
        end
        S_SEARCH: begin
          if (scan_found || last_chunk) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            chunk <= chunk + CIW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if ((state == S_SEARCH) && (scan_found || last_chunk)) begin
      granted_id <= scan_found ? IDW'(scan_pos + AW'(1)) : '0;
      none_free  <= !scan_found;
    end
  end

  // free map: returns land on accept, grants at the end of a search
  always_ff @(posedge clk) begin
    if (rst) begin
      free_map <= '1;
    end else begin
      if (acc && ret_valid) begin
        free_map[ret_idx[FIW-1:0]] <= 1'b1;
      end
      if ((state == S_SEARCH) && scan_found) begin
        free_map[scan_pos[FIW-1:0]] <= 1'b0;
      end
    end
  end

endmodule
